// ----- rtl/core/lcdn_pkg.sv -----
// Shared types, constants and the write table for the LCD nibble sequencer.
package lcdn_pkg;

	localparam int LineLengthDefault = 16;
	localparam int QueueDepthDefault = 2;

	localparam int PosW  = 6;
	localparam int PreW  = 27;
	localparam int PostW = 24;
	localparam int PreUsW  = 19;
	localparam int PostUsW = 16;
	localparam int StepW = 4;

	localparam logic [7:0] CyclesPerUsReset = 8'd27;

	// command bytes
	localparam logic [7:0] CmdFunctionSet = 8'b0010_1000;
	localparam logic [7:0] CmdEntryMode   = 8'b0000_0110;
	localparam logic [7:0] CmdDisplayOn   = 8'b0000_1111;
	localparam logic [7:0] CmdClear       = 8'b0000_0001;
	localparam logic [7:0] CmdSetAddr     = 8'b1000_0000;
	localparam logic [7:0] LineTwoAddr    = 8'h40;
	localparam logic [3:0] NibWake        = 4'b0011;
	localparam logic [3:0] NibFourBit     = 4'b0010;

	// delays in us
	localparam logic [PreUsW-1:0]  UsPowerUp = 19'd500000;
	localparam logic [PostUsW-1:0] UsWake1   = 16'd41000;
	localparam logic [PostUsW-1:0] UsWake2   = 16'd100;
	localparam logic [PostUsW-1:0] UsClear   = 16'd20000;
	localparam logic [PostUsW-1:0] UsCmd     = 16'd37;

	localparam logic RsCmd  = 1'b0;
	localparam logic RsData = 1'b1;

	typedef enum logic [1:0] {
		KIND_INIT     = 2'd0,
		KIND_CHAR     = 2'd1,
		KIND_CHAR_ADR = 2'd2,
		KIND_CHAR_CLR = 2'd3
	} lcdn_kind_t;

	typedef struct packed {
		lcdn_kind_t kind;
		logic [7:0] ch;
	} lcdn_desc_t;

	typedef struct packed {
		logic               rs;
		logic [3:0]         nib;
		logic [PreUsW-1:0]  pre_us;
		logic [PostUsW-1:0] post_us;
		logic               last;
	} lcdn_wr_t;

	localparam logic [StepW-1:0] StepInitLast = 4'd11;
	localparam logic [StepW-1:0] StepCharHi   = 4'd2;
	localparam logic [StepW-1:0] StepCharLo   = 4'd3;

	function automatic logic [StepW-1:0] lcdn_first_step(input lcdn_kind_t kind);
		logic [StepW-1:0] s;
		s = '0;
		if (kind == KIND_CHAR) s = StepCharHi;
		return s;
	endfunction

	// one nibble write of the sequence for a given kind and step
	function automatic lcdn_wr_t lcdn_write(input lcdn_kind_t kind, input logic [StepW-1:0] step,
		input logic [7:0] ch);
		lcdn_wr_t   w;
		logic [7:0] adr_cmd;
		adr_cmd = CmdSetAddr | (LineTwoAddr & 8'h7F);
		w = '{rs: RsCmd, nib: 4'h0, pre_us: '0, post_us: '0, last: 1'b0};
		if (kind == KIND_INIT) begin
			case (step)
				4'd0: begin
					w.nib = NibWake;
					w.pre_us = UsPowerUp;
					w.post_us = UsWake1;
				end
				4'd1: begin
					w.nib = NibWake;
					w.post_us = UsWake2;
				end
				4'd2: w.nib = NibWake;
				4'd3: w.nib = NibFourBit;
				4'd4: w.nib = CmdFunctionSet[7:4];
				4'd5: begin
					w.nib = CmdFunctionSet[3:0];
					w.post_us = UsCmd;
				end
				4'd6: w.nib = CmdClear[7:4];
				4'd7: begin
					w.nib = CmdClear[3:0];
					w.post_us = UsClear;
				end
				4'd8: w.nib = CmdEntryMode[7:4];
				4'd9: begin
					w.nib = CmdEntryMode[3:0];
					w.post_us = UsCmd;
				end
				4'd10: w.nib = CmdDisplayOn[7:4];
				4'd11: begin
					w.nib = CmdDisplayOn[3:0];
					w.post_us = UsCmd;
					w.last = 1'b1;
				end
				default: w.nib = 4'h0;
			endcase
		end else begin
			case (step)
				4'd0: w.nib = (kind == KIND_CHAR_CLR) ? CmdClear[7:4] : adr_cmd[7:4];
				4'd1: begin
					w.nib = (kind == KIND_CHAR_CLR) ? CmdClear[3:0] : adr_cmd[3:0];
					w.post_us = (kind == KIND_CHAR_CLR) ? UsClear : UsCmd;
				end
				4'd2: begin
					w.rs = RsData;
					w.nib = ch[7:4];
				end
				4'd3: begin
					w.rs = RsData;
					w.nib = ch[3:0];
					w.post_us = UsCmd;
					w.last = 1'b1;
				end
				default: w.nib = 4'h0;
			endcase
		end
		return w;
	endfunction

endpackage

// ----- rtl/core/char_lcd_nibble_sequencer_core.sv -----
// Top level of the 4-bit character LCD nibble sequencer.
// Each accepted item expands into a run of nibble writes for an HD44780-style
// display: an init item gives 12 command writes, a character item gives 2, or 4
// when a jump to the second line or a screen clear is put in front of it. The
// write sequencer emits one write per cycle while out_ready is high and an item
// is on hand; the step counter of that sequencer sets the rate. A two-entry queue
// lets the front end take new items while earlier ones are still being written
// out. Waits come out in clock cycles, as microseconds times cycles_per_us; the
// strobe timing itself is not included.
module char_lcd_nibble_sequencer_core #(
	parameter int LINE_LENGTH = lcdn_pkg::LineLengthDefault,
	parameter int QUEUE_DEPTH = lcdn_pkg::QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        register_select,
	output logic [3:0]  nibble,
	output logic [26:0] pre_wait_cycles,
	output logic [23:0] post_wait_cycles,
	output logic        last
);
	import lcdn_pkg::*;

	logic [7:0]  cycles_per_us_q;
	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_not_empty;
	lcdn_desc_t  push_desc;
	lcdn_desc_t  pop_desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycles_per_us_q <= CyclesPerUsReset;
		end else if (cfg_we) begin
			cycles_per_us_q <= cfg_wdata;
		end
	end

	lcdn_front #(
		.LINE_LENGTH(LINE_LENGTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.char_code (char_code),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_desc    (push_desc)
	);

	lcdn_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_desc),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (pop_desc)
	);

	lcdn_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cycles_per_us    (cycles_per_us_q),
		.q_not_empty      (q_not_empty),
		.q_desc           (pop_desc),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.register_select  (register_select),
		.nibble           (nibble),
		.pre_wait_cycles  (pre_wait_cycles),
		.post_wait_cycles (post_wait_cycles),
		.last             (last)
	);

`ifndef SYNTHESIS
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("item pushed into a full queue");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_not_empty)
		else $error("descriptor popped from an empty queue");

	a_data_no_pre: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && register_select |-> pre_wait_cycles == '0)
		else $error("data write carries a power-up wait");

	a_char_end_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && register_select && last |->
			post_wait_cycles == PostW'(PostW'(UsCmd) * PostW'(cycles_per_us_q)))
		else $error("final character write has wrong post wait");
`endif

endmodule

// ----- rtl/core/lcdn_front.sv -----
// Front end: accepts items, tracks the cursor position and classifies each item.
module lcdn_front #(
	parameter int LINE_LENGTH = lcdn_pkg::LineLengthDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                op,
	input  logic [7:0]          char_code,
	input  logic                q_full,
	output logic                q_push,
	output lcdn_pkg::lcdn_desc_t q_desc
);
	import lcdn_pkg::*;

	localparam logic [PosW:0] LineEnd   = (PosW+1)'(LINE_LENGTH);
	localparam logic [PosW:0] ScreenEnd = (PosW+1)'(2 * LINE_LENGTH);

	logic [PosW-1:0] char_position_q;
	logic            at_line_end;
	logic            at_screen_end;
	logic [PosW-1:0] pos_base;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	assign at_line_end   = {1'b0, char_position_q} == LineEnd;
	assign at_screen_end = {1'b0, char_position_q} == ScreenEnd;

	always_comb begin
		q_desc.ch = char_code;
		if (!op)                q_desc.kind = KIND_INIT;
		else if (at_line_end)   q_desc.kind = KIND_CHAR_ADR;
		else if (at_screen_end) q_desc.kind = KIND_CHAR_CLR;
		else                    q_desc.kind = KIND_CHAR;
	end

	// a clear restarts the count before this character is counted
	assign pos_base = (!at_line_end && at_screen_end) ? '0 : char_position_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_position_q <= '0;
		end else if (q_push && op) begin
			char_position_q <= pos_base + 1'b1;
		end
	end

endmodule

// ----- rtl/core/lcdn_fifo.sv -----
// Small descriptor queue between the front end and the write sequencer.
module lcdn_fifo #(
	parameter int DEPTH = lcdn_pkg::QueueDepthDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lcdn_pkg::lcdn_desc_t push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output lcdn_pkg::lcdn_desc_t pop_data
);
	import lcdn_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
	localparam logic [CW-1:0] Full    = CW'(DEPTH);

	lcdn_desc_t      slot_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = count_q == Full;
	assign not_empty = count_q != '0;
	assign pop_data  = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- rtl/core/lcdn_back.sv -----
// Write sequencer: steps through a descriptor and emits one nibble write per cycle while the output is not stalled.
module lcdn_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           cycles_per_us,
	input  logic                 q_not_empty,
	input  lcdn_pkg::lcdn_desc_t q_desc,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 register_select,
	output logic [3:0]           nibble,
	output logic [26:0]          pre_wait_cycles,
	output logic [23:0]          post_wait_cycles,
	output logic                 last
);
	import lcdn_pkg::*;

	logic              busy_q;
	lcdn_kind_t        kind_q;
	logic [7:0]        ch_q;
	logic [StepW-1:0]  step_q;
	logic              out_valid_q;
	logic              rs_q;
	logic [3:0]        nib_q;
	logic [PreW-1:0]   pre_q;
	logic [PostW-1:0]  post_q;
	logic              last_q;

	lcdn_wr_t          wr;
	logic              adv;
	logic              emit;
	logic [PreW-1:0]   pre_prod;
	logic [PostW-1:0]  post_prod;

	assign wr        = lcdn_write(kind_q, step_q, ch_q);
	assign adv       = !out_valid_q || out_ready;
	assign emit      = adv && busy_q;
	assign q_pop     = adv && q_not_empty && (!busy_q || wr.last);
	assign pre_prod  = PreW'(wr.pre_us) * PreW'(cycles_per_us);
	assign post_prod = PostW'(wr.post_us) * PostW'(cycles_per_us);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_INIT;
			step_q      <= '0;
		end else begin
			if (adv) out_valid_q <= busy_q;
			if (q_pop) begin
				busy_q <= 1'b1;
				kind_q <= q_desc.kind;
				step_q <= lcdn_first_step(q_desc.kind);
			end else if (emit) begin
				if (wr.last) busy_q <= 1'b0;
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) ch_q <= q_desc.ch;
		if (emit) begin
			rs_q   <= wr.rs;
			nib_q  <= wr.nib;
			pre_q  <= pre_prod;
			post_q <= post_prod;
			last_q <= wr.last;
		end
	end

	assign out_valid        = out_valid_q;
	assign register_select  = rs_q;
	assign nibble           = nib_q;
	assign pre_wait_cycles  = pre_q;
	assign post_wait_cycles = post_q;
	assign last             = last_q;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the 4-bit character LCD nibble sequencer.
module tb_top;

	localparam int LINE_LEN       = 16;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 400;
	localparam int MAX_REPORTS    = 200;

	localparam logic OP_INIT = 1'b0;
	localparam logic OP_CHAR = 1'b1;
	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	localparam logic [7:0] CMD_FUNC  = 8'h28;
	localparam logic [7:0] CMD_ENTRY = 8'h06;
	localparam logic [7:0] CMD_DISP  = 8'h0F;
	localparam logic [7:0] CMD_CLEAR = 8'h01;
	localparam logic [7:0] CMD_LINE2 = 8'hC0;
	localparam logic [3:0] NIB_WAKE  = 4'h3;
	localparam logic [3:0] NIB_4BIT  = 4'h2;

	localparam int unsigned US_POWER = 500000;
	localparam int unsigned US_WAKE1 = 41000;
	localparam int unsigned US_WAKE2 = 100;
	localparam int unsigned US_CLEAR = 20000;
	localparam int unsigned US_CMD   = 37;

	localparam logic [7:0] RATE_RESET = 8'd27;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_COIN,
		RX_QUARTER,
		RX_MOSTLY
	} rx_mode_t;

	typedef struct packed {
		logic        op;
		logic [7:0]  code;
	} lcd_item_t;

	typedef struct packed {
		logic        rs;
		logic [3:0]  nib;
		logic [26:0] pre;
		logic [23:0] post;
		logic        last;
	} lcd_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        op = OP_INIT;
	logic [7:0]  char_code = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        register_select;
	logic [3:0]  nibble;
	logic [26:0] pre_wait_cycles;
	logic [23:0] post_wait_cycles;
	logic        last;

	char_lcd_nibble_sequencer_core #(
		.LINE_LENGTH(LINE_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.register_select(register_select),
		.nibble(nibble),
		.pre_wait_cycles(pre_wait_cycles),
		.post_wait_cycles(post_wait_cycles),
		.last(last)
	);

	always #5 clk = ~clk;

	lcd_item_t   pending_items[$];
	lcd_write_t  due_writes[$];
	int unsigned items_queued = 0;
	int unsigned items_taken = 0;
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;

	// shadow of the block's state
	logic [7:0]  lcd_rate = RATE_RESET;
	logic [5:0]  lcd_pos = 6'd0;

	logic        in_taken = 1'b0;

	task automatic put_nibble(input logic rs, input logic [3:0] nib,
		input int unsigned pre_us, input int unsigned post_us, input logic is_last);
		lcd_write_t  w;
		logic [63:0] pre_prod;
		logic [63:0] post_prod;
		pre_prod = 64'(pre_us) * 64'(lcd_rate);
		post_prod = 64'(post_us) * 64'(lcd_rate);
		w.rs = rs;
		w.nib = nib;
		w.pre = pre_prod[26:0];
		w.post = post_prod[23:0];
		w.last = is_last;
		due_writes.push_back(w);
	endtask

	task automatic put_byte(input logic rs, input logic [7:0] b,
		input int unsigned post_us, input logic is_last);
		put_nibble(rs, b[7:4], 0, 0, 1'b0);
		put_nibble(rs, b[3:0], 0, post_us, is_last);
	endtask

	task automatic expand_item(input logic op_i, input logic [7:0] ch);
		if (op_i == OP_INIT) begin
			put_nibble(RS_CMD, NIB_WAKE, US_POWER, US_WAKE1, 1'b0);
			put_nibble(RS_CMD, NIB_WAKE, 0, US_WAKE2, 1'b0);
			put_nibble(RS_CMD, NIB_WAKE, 0, 0, 1'b0);
			put_nibble(RS_CMD, NIB_4BIT, 0, 0, 1'b0);
			put_byte(RS_CMD, CMD_FUNC, US_CMD, 1'b0);
			put_byte(RS_CMD, CMD_CLEAR, US_CLEAR, 1'b0);
			put_byte(RS_CMD, CMD_ENTRY, US_CMD, 1'b0);
			put_byte(RS_CMD, CMD_DISP, US_CMD, 1'b1);
		end else begin
			if (lcd_pos == LINE_LEN) begin
				put_byte(RS_CMD, CMD_LINE2, US_CMD, 1'b0);
			end else if (lcd_pos == 2 * LINE_LEN) begin
				put_byte(RS_CMD, CMD_CLEAR, US_CLEAR, 1'b0);
				lcd_pos = 6'd0;
			end
			put_byte(RS_DATA, ch, US_CMD, 1'b1);
			lcd_pos = lcd_pos + 6'd1;
		end
	endtask

	// prediction, checking and watchdog, all on the rising edge
	always @(posedge clk) begin
		lcd_write_t exp_w;
		lcd_write_t got_w;
		logic       moved;
		moved = 1'b0;
		in_taken <= in_valid && in_ready;
		if (arst_n) begin
			if (cfg_we) lcd_rate = cfg_wdata;
			if (in_valid && in_ready) begin
				expand_item(op, char_code);
				items_taken++;
				moved = 1'b1;
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				got_w = '{register_select, nibble, pre_wait_cycles, post_wait_cycles, last};
				if (due_writes.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected write rs=%b nib=%h pre=%0d post=%0d last=%b",
							$time, got_w.rs, got_w.nib, got_w.pre, got_w.post, got_w.last);
				end else begin
					exp_w = due_writes.pop_front();
					if (got_w !== exp_w) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: expected rs=%b nib=%h pre=%0d post=%0d last=%b, got rs=%b nib=%h pre=%0d post=%0d last=%b",
								$time, exp_w.rs, exp_w.nib, exp_w.pre, exp_w.post, exp_w.last,
								got_w.rs, got_w.nib, got_w.pre, got_w.post, got_w.last);
					end
				end
			end
		end
		if (moved) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// sender: bursts of items with random gaps
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(negedge clk) begin
		lcd_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			// hold the item until it is taken
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left--;
		end else if (pending_items.size() > 0) begin
			nxt = pending_items.pop_front();
			op <= nxt.op;
			char_code <= nxt.code;
			in_valid <= 1'b1;
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 12);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left--;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver: stall modes picked at random and held for a random stretch, plus long hold-offs
	rx_mode_t    rx_mode = RX_FREE;
	int unsigned mode_left = 0;
	int unsigned hold_left = 0;
	int unsigned holds_done = 0;
	int unsigned hold_at = 60;
	logic [1:0]  rx_tick = 2'd0;

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (holds_done < 2 && items_taken >= hold_at && pending_items.size() > 12) begin
			// sender keeps offering while nothing drains, so the input backs up
			out_ready <= 1'b0;
			hold_left = HOLD_CYCLES;
			holds_done++;
			hold_at = hold_at + 200;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end else begin
				mode_left--;
			end
			rx_tick = rx_tick + 2'd1;
			case (rx_mode)
				RX_FREE:    out_ready <= 1'b1;
				RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
				RX_QUARTER: out_ready <= (rx_tick == 2'd0);
				default:    out_ready <= ($urandom_range(0, 4) != 0);
			endcase
		end
	end

	task automatic write_rate(input logic [7:0] v);
		@(negedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic queue_item(input logic op_i, input logic [7:0] code_i);
		pending_items.push_back('{op_i, code_i});
		items_queued++;
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (items_taken != items_queued || due_writes.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		logic [7:0] rates[5];
		int unsigned p;
		int unsigned k;
		rates[0] = 8'd0;
		rates[1] = 8'd255;
		rates[2] = 8'd1;
		rates[3] = 8'($urandom_range(2, 254));
		rates[4] = RATE_RESET;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: init, field extremes, line-two jump, init leaving position alone
		write_rate(RATE_RESET);
		queue_item(OP_INIT, 8'h00);
		queue_item(OP_CHAR, 8'h00);
		queue_item(OP_CHAR, 8'hFF);
		queue_item(OP_CHAR, 8'hA5);
		queue_item(OP_CHAR, 8'h5A);
		for (k = 0; k < 11; k++) queue_item(OP_CHAR, 8'(8'h41 + k));
		queue_item(OP_INIT, 8'hFF);
		queue_item(OP_CHAR, 8'h30);
		queue_item(OP_CHAR, 8'h7E);
		queue_item(OP_CHAR, 8'h80);
		queue_item(OP_INIT, 8'h55);
		queue_item(OP_CHAR, 8'h0F);
		queue_item(OP_CHAR, 8'hF0);
		wait_drained();

		// random phases, one per rate setting; chars dominate so the clear comes often
		for (p = 0; p < 5; p++) begin
			write_rate(rates[p]);
			for (k = 0; k < 80; k++) begin
				if ($urandom_range(0, 99) < 12) queue_item(OP_INIT, 8'($urandom));
				else queue_item(OP_CHAR, 8'($urandom));
			end
			wait_drained();
		end

		repeat (20) @(negedge clk);
		if (mismatches == 0 && due_writes.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/lcdn_pkg.sv
rtl/core/lcdn_front.sv
rtl/core/lcdn_fifo.sv
rtl/core/lcdn_back.sv
rtl/core/char_lcd_nibble_sequencer_core.sv
bench/tb_top.sv
